// ===== rtl/prq_pkg.sv =====
// Package for the priority ready queue: sizes, opcodes and the
// controller/datapath command and status structs. No dependencies.
package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PID_BITS    = 16;
    localparam int PRIO_BITS   = 8;
    localparam int OP_W        = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd3;
    localparam logic [OP_W-1:0] OP_POP      = 3'd4;

    typedef struct packed {
        logic load;       // latch request word, clear result, index to head
        logic step;       // advance scan index
        logic idx_tail;   // move index to the tail
        logic place;      // insert latched entry at index
        logic delete;     // drop entry at index
        logic take_head;  // capture head entry into the result
        logic set_ok;     // mark the result successful
        logic emit;       // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            at_end;
        logic            prio_gt;
        logic            pid_eq;
        logic            out_busy;
    } t_dp_status;

endpackage

// ===== rtl/prq_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on prq_pkg.
interface prq_req_if import prq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [PID_BITS-1:0]  pid;
    logic [PRIO_BITS-1:0] priority_req;

    modport source (output valid, output opcode, output pid, output priority_req,
                    input ready);
    modport sink   (input valid, input opcode, input pid, input priority_req,
                    output ready);
endinterface

interface prq_rsp_if import prq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [PID_BITS-1:0]  out_pid;
    logic [PRIO_BITS-1:0] out_priority;
    logic [CNT_W-1:0]     count;

    modport source (output valid, output ok, output out_pid, output out_priority,
                    output count, input ready);
    modport sink   (input valid, input ok, input out_pid, input out_priority,
                    input count, output ready);
endinterface

// ===== rtl/prq_datapath.sv =====
// Datapath: slot register file, entry count, scan index, result and output register.
// Depends on prq_pkg.
module prq_datapath import prq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [PID_BITS-1:0]  i_pid,
    input  logic [PRIO_BITS-1:0] i_priority_req,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_ok,
    output logic [PID_BITS-1:0]  o_out_pid,
    output logic [PRIO_BITS-1:0] o_out_priority,
    output logic [CNT_W-1:0]     o_count
);

    logic [PID_BITS-1:0]  r_slot_pid  [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] r_slot_prio [QUEUE_DEPTH];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_idx;
    logic [OP_W-1:0]      r_op;
    logic [PID_BITS-1:0]  r_pid;
    logic [PRIO_BITS-1:0] r_prio;
    logic                 r_res_ok;
    logic [PID_BITS-1:0]  r_res_pid;
    logic [PRIO_BITS-1:0] r_res_prio;
    logic                 r_out_valid;
    logic                 r_ok;
    logic [PID_BITS-1:0]  r_out_pid;
    logic [PRIO_BITS-1:0] r_out_prio;
    logic [CNT_W-1:0]     r_out_count;

    logic [PID_BITS-1:0]  cur_pid;
    logic [PRIO_BITS-1:0] cur_prio;

    assign cur_pid  = r_slot_pid[r_idx[IDX_W-1:0]];
    assign cur_prio = r_slot_prio[r_idx[IDX_W-1:0]];

    always_comb begin
        o_status.op       = r_op;
        o_status.full     = (r_count == CNT_W'(QUEUE_DEPTH));
        o_status.empty    = (r_count == '0);
        o_status.at_end   = (r_idx == r_count);
        o_status.prio_gt  = (cur_prio > r_prio);
        o_status.pid_eq   = (cur_pid == r_pid);
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    // slot file: entries shift up on place, down on delete
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.place) begin
                if (CNT_W'(i) == r_idx) begin
                    r_slot_pid[i]  <= r_pid;
                    r_slot_prio[i] <= r_prio;
                end else if (i > 0 && CNT_W'(i) > r_idx) begin
                    r_slot_pid[i]  <= r_slot_pid[(i > 0) ? i - 1 : 0];
                    r_slot_prio[i] <= r_slot_prio[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.delete) begin
                if (i < QUEUE_DEPTH - 1 && CNT_W'(i) >= r_idx) begin
                    r_slot_pid[i]  <= r_slot_pid[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                    r_slot_prio[i] <= r_slot_prio[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_tail) begin
                r_idx <= r_count;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.place) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.delete) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_pid      <= i_pid;
            r_prio     <= i_priority_req;
            r_res_ok   <= 1'b0;
            r_res_pid  <= '0;
            r_res_prio <= '0;
        end else begin
            if (i_cmd.set_ok) begin
                r_res_ok <= 1'b1;
            end
            if (i_cmd.take_head) begin
                r_res_pid  <= r_slot_pid[0];
                r_res_prio <= r_slot_prio[0];
            end
        end
        if (i_cmd.emit) begin
            r_ok        <= r_res_ok;
            r_out_pid   <= r_res_pid;
            r_out_prio  <= r_res_prio;
            r_out_count <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_ok;
    assign o_out_pid      = r_out_pid;
    assign o_out_priority = r_out_prio;
    assign o_count        = r_out_count;

endmodule

// ===== rtl/prq_ctrl.sv =====
// Controller: sequences decode, scan, place/delete and result hand-off.
// Depends on prq_pkg.
module prq_ctrl import prq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PLACE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.op)
                    OP_APPEND: begin
                        if (i_status.full) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.idx_tail = 1'b1;
                            n_state        = S_PLACE;
                        end
                    end
                    OP_INSERT: begin
                        n_state = i_status.full ? S_DONE : S_SCAN;
                    end
                    OP_REMOVE, OP_CONTAINS: begin
                        n_state = S_SCAN;
                    end
                    OP_POP: begin
                        if (!i_status.empty) begin
                            o_cmd.take_head = 1'b1;
                            o_cmd.delete    = 1'b1;
                            o_cmd.set_ok    = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_status.op == OP_INSERT) begin
                    if (i_status.at_end || i_status.prio_gt) begin
                        o_cmd.place  = 1'b1;
                        o_cmd.set_ok = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    if (i_status.at_end) begin
                        n_state = S_DONE;
                    end else if (i_status.pid_eq) begin
                        o_cmd.delete = (i_status.op == OP_REMOVE);
                        o_cmd.set_ok = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_PLACE: begin
                o_cmd.place  = 1'b1;
                o_cmd.set_ok = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/pid_priority_ready_queue.sv =====
// Top level of the priority ready queue: controller plus datapath.
// Depends on prq_pkg, prq_if, prq_ctrl, prq_datapath.
//
// Request channel i_req carries opcode, pid and priority_req; each word gives
// exactly one response word on o_rsp: ok, out_pid, out_priority, count.
// Opcodes: append at tail, insert by priority (stable among equal values),
// remove first matching pid, test for pid, pop head.
// The controller works on one request at a time. Pop and refused or unknown
// requests go from decode straight to done; append goes through the place
// state; insert, remove and contains scan the slots from the head, one slot
// per step, and stop at a match, at a larger priority (insert) or at the end
// of the queue. A new request is accepted the cycle after the response is
// loaded.
// Reset (synchronous, active low) empties the queue and drops any response.
// The response sits in an output register; while the receiver stalls, one more
// request may be accepted and processed, and it waits for the register to free.
module pid_priority_ready_queue import prq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prq_req_if.sink     i_req,
    prq_rsp_if.source   o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       req_ready;

    assign i_req.ready = req_ready;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    prq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_req.opcode),
        .i_pid          (i_req.pid),
        .i_priority_req (i_req.priority_req),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_ok           (o_rsp.ok),
        .o_out_pid      (o_rsp.out_pid),
        .o_out_priority (o_rsp.out_priority),
        .o_count        (o_rsp.count)
    );

endmodule
